FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define SIRT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property, checked in and out of reset.
`define SIRT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/sirt_pkg.sv
package sirt_pkg;

    typedef enum logic [2:0] {
        MODE_STUDY  = 3'd0,
        MODE_REST   = 3'd1,
        MODE_PAUSED = 3'd2,
        MODE_CONFIG = 3'd3,
        MODE_ALERT  = 3'd4
    } t_mode;

    // display colors
    localparam logic [2:0] COLOR_OFF    = 3'd0;
    localparam logic [2:0] COLOR_GREEN  = 3'd1;
    localparam logic [2:0] COLOR_RED    = 3'd2;
    localparam logic [2:0] COLOR_YELLOW = 3'd3;
    localparam logic [2:0] COLOR_WHITE  = 3'd4;

    // register indexes (paddr[4:2])
    localparam logic [2:0] REG_POLLS_PER_SEC = 3'd0;
    localparam logic [2:0] REG_BLINK_POLLS   = 3'd1;
    localparam logic [2:0] REG_LONG_POLLS    = 3'd2;
    localparam logic [2:0] REG_FLASH_POLLS   = 3'd3;
    localparam logic [2:0] REG_AXIS_LOW      = 3'd4;
    localparam logic [2:0] REG_AXIS_HIGH     = 3'd5;
    localparam logic [2:0] REG_MIN_MINUTES   = 3'd6;
    localparam logic [2:0] REG_MAX_MINUTES   = 3'd7;

    // status LED bit positions
    localparam int LED_STUDY  = 0;
    localparam int LED_REST   = 1;
    localparam int LED_CONFIG = 2;

    // matrix size, shown units saturate at 63
    localparam int MATRIX_CELLS = 25;
    localparam logic [5:0] MATRIX_UNITS =
        (MATRIX_CELLS > 63) ? 6'd63 : 6'(MATRIX_CELLS);

    // x / 15 == (x * 4370) >> 16 for x < 4681
    localparam logic [12:0] DIV15_MUL   = 13'd4370;
    localparam logic [5:0]  UNITS_MAX   = 6'd63;

    // register reset values
    localparam logic [7:0]  RST_POLLS_PER_SEC = 8'd10;
    localparam logic [7:0]  RST_BLINK_POLLS   = 8'd5;
    localparam logic [7:0]  RST_LONG_POLLS    = 8'd20;
    localparam logic [7:0]  RST_FLASH_POLLS   = 8'd2;
    localparam logic [11:0] RST_AXIS_LOW      = 12'd150;
    localparam logic [11:0] RST_AXIS_HIGH     = 12'd4000;
    localparam logic [5:0]  RST_MIN_MINUTES   = 6'd1;
    localparam logic [5:0]  RST_MAX_MINUTES   = 6'd50;
    localparam logic [5:0]  RST_STUDY_MINS    = 6'd25;
    localparam logic [5:0]  RST_REST_MINS     = 6'd5;
    localparam logic [11:0] RST_REMAINING     = 12'd1500;

    // minutes * 60 as shifts
    function automatic logic [11:0] phase_secs(input logic [5:0] mins);
        logic [11:0] m;
        m = {6'd0, mins};
        return (m << 6) - (m << 2);
    endfunction

endpackage

FILE: rtl/core/study_rest_interval_timer.sv
// Path: an accepted poll is held in the input register and loads the result register
//   once the output can take it; its result transfer leaves from the result register.
// Throughput: one poll per cycle while the result output is not stalled; the poll
//   update and units division are one combinational pass between the two registers.
// Reset: synchronous, active low; clears the pipeline valids, the timer state and
//   the configuration registers to their defaults. No clearing pass.
module study_rest_interval_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // poll input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [0] phase_button, [1] pause_button,
                                       // [2] joy_button, [14:3] joy_axis, [15] zero
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [2:0] mode, [14:3] seconds_left,
                                       // [20:15] display_units, [23:21] display_color,
                                       // [24] study_led, [25] rest_led,
                                       // [26] config_led, [31:27] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  r_polls_per_sec;
    logic [7:0]  r_blink_polls;
    logic [7:0]  r_long_polls;
    logic [7:0]  r_flash_polls;
    logic [11:0] r_axis_low;
    logic [11:0] r_axis_high;
    logic [5:0]  r_min_minutes;
    logic [5:0]  r_max_minutes;

    logic        w_cfg_wr;
    logic [2:0]  w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_polls_per_sec <= sirt_pkg::RST_POLLS_PER_SEC;
            r_blink_polls   <= sirt_pkg::RST_BLINK_POLLS;
            r_long_polls    <= sirt_pkg::RST_LONG_POLLS;
            r_flash_polls   <= sirt_pkg::RST_FLASH_POLLS;
            r_axis_low      <= sirt_pkg::RST_AXIS_LOW;
            r_axis_high     <= sirt_pkg::RST_AXIS_HIGH;
            r_min_minutes   <= sirt_pkg::RST_MIN_MINUTES;
            r_max_minutes   <= sirt_pkg::RST_MAX_MINUTES;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                sirt_pkg::REG_POLLS_PER_SEC: r_polls_per_sec <= pwdata[7:0];
                sirt_pkg::REG_BLINK_POLLS:   r_blink_polls   <= pwdata[7:0];
                sirt_pkg::REG_LONG_POLLS:    r_long_polls    <= pwdata[7:0];
                sirt_pkg::REG_FLASH_POLLS:   r_flash_polls   <= pwdata[7:0];
                sirt_pkg::REG_AXIS_LOW:      r_axis_low      <= pwdata[11:0];
                sirt_pkg::REG_AXIS_HIGH:     r_axis_high     <= pwdata[11:0];
                sirt_pkg::REG_MIN_MINUTES:   r_min_minutes   <= pwdata[5:0];
                sirt_pkg::REG_MAX_MINUTES:   r_max_minutes   <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            sirt_pkg::REG_POLLS_PER_SEC: prdata = {24'd0, r_polls_per_sec};
            sirt_pkg::REG_BLINK_POLLS:   prdata = {24'd0, r_blink_polls};
            sirt_pkg::REG_LONG_POLLS:    prdata = {24'd0, r_long_polls};
            sirt_pkg::REG_FLASH_POLLS:   prdata = {24'd0, r_flash_polls};
            sirt_pkg::REG_AXIS_LOW:      prdata = {20'd0, r_axis_low};
            sirt_pkg::REG_AXIS_HIGH:     prdata = {20'd0, r_axis_high};
            sirt_pkg::REG_MIN_MINUTES:   prdata = {26'd0, r_min_minutes};
            sirt_pkg::REG_MAX_MINUTES:   prdata = {26'd0, r_max_minutes};
            default:                     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline: input register -> update -> result register.
    // The timer state moves only when the input register hands its poll on.
    // ------------------------------------------------------------------
    logic        r_in_valid;
    logic        r_in_phase;
    logic        r_in_pause;
    logic        r_in_joy;
    logic [11:0] r_in_axis;

    logic        r_out_valid;
    logic [31:0] r_out_data;

    logic        w_adv;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_phase <= s_axis_tdata[0];
            r_in_pause <= s_axis_tdata[1];
            r_in_joy   <= s_axis_tdata[2];
            r_in_axis  <= s_axis_tdata[14:3];
        end
    end

    // ------------------------------------------------------------------
    // Timer state
    // ------------------------------------------------------------------
    sirt_pkg::t_mode r_mode,       n_mode;
    logic            r_saved,      n_saved;      // 0 study, 1 rest
    logic [11:0]     r_remaining,  n_remaining;
    logic [5:0]      r_study_mins, n_study_mins;
    logic [5:0]      r_rest_mins,  n_rest_mins;
    logic [7:0]      r_sec_count,  n_sec_count;
    logic [7:0]      r_blink_cnt,  n_blink_cnt;
    logic            r_blink_lvl,  n_blink_lvl;
    logic [7:0]      r_press_cnt,  n_press_cnt;
    logic            r_long_done,  n_long_done;
    logic [2:0]      r_prev,       n_prev;       // {joy, pause, phase}
    logic [7:0]      r_flash_cnt,  n_flash_cnt;
    logic            r_flash_lvl,  n_flash_lvl;
    logic [2:0]      r_led,        n_led;
    logic [5:0]      r_shown,      n_shown;

    logic            w_ph_fall;
    logic            w_pa_fall;
    logic            w_jy_fall;
    logic [5:0]      w_edit_mins;
    logic [5:0]      w_stepped;
    logic            w_led_bit;

    assign w_ph_fall = r_prev[0] && !r_in_phase;
    assign w_pa_fall = r_prev[1] && !r_in_pause;
    assign w_jy_fall = r_prev[2] && !r_in_joy;

    // minutes step for config mode, on the saved phase's length
    assign w_edit_mins = r_saved ? r_rest_mins : r_study_mins;
    always_comb begin
        if (r_in_axis <= r_axis_low && w_edit_mins > r_min_minutes) begin
            w_stepped = w_edit_mins - 6'd1;
        end else if (r_in_axis >= r_axis_high && w_edit_mins < r_max_minutes) begin
            w_stepped = w_edit_mins + 6'd1;
        end else begin
            w_stepped = w_edit_mins;
        end
    end

    // next state
    always_comb begin
        n_mode       = r_mode;
        n_saved      = r_saved;
        n_remaining  = r_remaining;
        n_study_mins = r_study_mins;
        n_rest_mins  = r_rest_mins;
        n_sec_count  = r_sec_count;
        n_blink_cnt  = r_blink_cnt;
        n_blink_lvl  = r_blink_lvl;
        n_press_cnt  = r_press_cnt;
        n_long_done  = r_long_done;
        n_flash_cnt  = r_flash_cnt;
        n_flash_lvl  = r_flash_lvl;
        n_led        = r_led;
        w_led_bit    = 1'b0;

        // long joystick press, ignored during alert
        if (r_mode != sirt_pkg::MODE_ALERT) begin
            if (w_jy_fall) begin
                n_press_cnt = 8'd0;
                n_long_done = 1'b0;
            end
            if (!r_in_joy && !n_long_done) begin
                if (n_press_cnt != 8'hFF) begin
                    n_press_cnt = n_press_cnt + 8'd1;
                end
                if (n_press_cnt > r_long_polls) begin
                    n_led[sirt_pkg::LED_CONFIG] = 1'b0;
                    n_long_done = 1'b1;
                    if (r_mode == sirt_pkg::MODE_CONFIG) begin
                        n_mode = n_saved ? sirt_pkg::MODE_REST : sirt_pkg::MODE_STUDY;
                    end else begin
                        if (r_mode != sirt_pkg::MODE_PAUSED) begin
                            n_saved = r_mode[0];
                        end
                        n_mode = sirt_pkg::MODE_CONFIG;
                        n_led  = 3'd0;
                        n_led[sirt_pkg::LED_CONFIG] = 1'b1;
                    end
                end
            end
        end

        if (n_mode == sirt_pkg::MODE_CONFIG) begin
            if (n_saved) begin
                n_rest_mins = w_stepped;
            end else begin
                n_study_mins = w_stepped;
            end
            n_remaining = sirt_pkg::phase_secs(w_stepped);
        end else if (n_mode == sirt_pkg::MODE_ALERT) begin
            if (!r_in_phase) begin
                // phase button held: next phase at full length
                n_saved     = !n_saved;
                n_mode      = n_saved ? sirt_pkg::MODE_REST : sirt_pkg::MODE_STUDY;
                n_remaining = sirt_pkg::phase_secs(n_saved ? n_rest_mins : n_study_mins);
                n_sec_count = 8'd0;
            end else begin
                n_flash_cnt = n_flash_cnt + 8'd1;
                if (n_flash_cnt >= r_flash_polls) begin
                    n_flash_lvl = !n_flash_lvl;
                    n_flash_cnt = 8'd0;
                end
            end
        end else begin
            // study, rest or paused
            if (w_ph_fall && n_mode != sirt_pkg::MODE_PAUSED) begin
                n_saved     = !n_mode[0];
                n_mode      = n_saved ? sirt_pkg::MODE_REST : sirt_pkg::MODE_STUDY;
                n_remaining = sirt_pkg::phase_secs(n_saved ? n_rest_mins : n_study_mins);
            end
            if (w_pa_fall) begin
                if (n_mode != sirt_pkg::MODE_PAUSED) begin
                    n_saved = n_mode[0];
                    n_mode  = sirt_pkg::MODE_PAUSED;
                end else begin
                    n_mode = n_saved ? sirt_pkg::MODE_REST : sirt_pkg::MODE_STUDY;
                end
            end
            if (n_mode == sirt_pkg::MODE_STUDY || n_mode == sirt_pkg::MODE_REST) begin
                n_sec_count = n_sec_count + 8'd1;
                if (n_sec_count >= r_polls_per_sec) begin
                    n_sec_count = 8'd0;
                    if (n_remaining != 12'd0) begin
                        n_remaining = n_remaining - 12'd1;
                    end else if (!r_in_phase) begin
                        // time out with the button already held: switch at once
                        n_saved     = !n_mode[0];
                        n_mode      = n_saved ? sirt_pkg::MODE_REST : sirt_pkg::MODE_STUDY;
                        n_remaining = sirt_pkg::phase_secs(
                                          n_saved ? n_rest_mins : n_study_mins);
                    end else begin
                        n_saved     = n_mode[0];
                        n_mode      = sirt_pkg::MODE_ALERT;
                        n_flash_lvl = 1'b1;
                        n_flash_cnt = 8'd0;
                    end
                end
            end else begin
                // paused: saved phase's LED blinks
                n_blink_cnt = n_blink_cnt + 8'd1;
                if (n_blink_cnt >= r_blink_polls) begin
                    n_blink_lvl = !n_blink_lvl;
                    w_led_bit   = n_blink_lvl;
                    if (n_saved) begin
                        n_led[sirt_pkg::LED_REST] = w_led_bit;
                    end else begin
                        n_led[sirt_pkg::LED_STUDY] = w_led_bit;
                    end
                    n_blink_cnt = 8'd0;
                end
            end
        end
    end

    // edge memory sees every poll, in every mode
    assign n_prev = {r_in_joy, r_in_pause, r_in_phase};

    // ------------------------------------------------------------------
    // Display outputs from the updated state
    // ------------------------------------------------------------------
    logic [12:0] w_round;     // remaining + 59
    logic [23:0] w_prod;      // (round / 4) * 4370
    logic [7:0]  w_quot;      // ceil(remaining / 60)
    logic [5:0]  w_units_run;
    logic [5:0]  n_units;
    logic [2:0]  n_color;
    logic [2:0]  w_phase_color;

    assign w_round       = {1'b0, n_remaining} + 13'd59;
    assign w_prod        = {13'd0, w_round[12:2]} * {11'd0, sirt_pkg::DIV15_MUL};
    assign w_quot        = w_prod[23:16];
    assign w_units_run   = (w_quot > {2'd0, sirt_pkg::UNITS_MAX}) ?
                           sirt_pkg::UNITS_MAX : w_quot[5:0];
    assign w_phase_color = n_saved ? sirt_pkg::COLOR_RED : sirt_pkg::COLOR_GREEN;

    always_comb begin
        n_shown = r_shown;
        case (n_mode)
            sirt_pkg::MODE_ALERT: begin
                n_units = n_flash_lvl ? sirt_pkg::MATRIX_UNITS : 6'd0;
                if (!n_flash_lvl) begin
                    n_color = sirt_pkg::COLOR_OFF;
                end else if (n_saved) begin
                    n_color = sirt_pkg::COLOR_WHITE;
                end else begin
                    n_color = sirt_pkg::COLOR_YELLOW;
                end
            end
            sirt_pkg::MODE_PAUSED: begin
                n_units = r_shown;
                n_color = w_phase_color;
            end
            default: begin
                n_units = w_units_run;
                n_shown = w_units_run;
                n_color = w_phase_color;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sirt_pkg::MODE_STUDY;
            r_saved      <= 1'b0;
            r_remaining  <= sirt_pkg::RST_REMAINING;
            r_study_mins <= sirt_pkg::RST_STUDY_MINS;
            r_rest_mins  <= sirt_pkg::RST_REST_MINS;
            r_sec_count  <= 8'd0;
            r_blink_cnt  <= 8'd0;
            r_blink_lvl  <= 1'b0;
            r_press_cnt  <= 8'd0;
            r_long_done  <= 1'b0;
            r_prev       <= 3'b111;
            r_flash_cnt  <= 8'd0;
            r_flash_lvl  <= 1'b1;
            r_led        <= 3'd0;
            r_shown      <= 6'd0;
        end else if (w_adv) begin
            r_mode       <= n_mode;
            r_saved      <= n_saved;
            r_remaining  <= n_remaining;
            r_study_mins <= n_study_mins;
            r_rest_mins  <= n_rest_mins;
            r_sec_count  <= n_sec_count;
            r_blink_cnt  <= n_blink_cnt;
            r_blink_lvl  <= n_blink_lvl;
            r_press_cnt  <= n_press_cnt;
            r_long_done  <= n_long_done;
            r_prev       <= n_prev;
            r_flash_cnt  <= n_flash_cnt;
            r_flash_lvl  <= n_flash_lvl;
            r_led        <= n_led;
            r_shown      <= n_shown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {5'd0,
                           n_led[sirt_pkg::LED_CONFIG],
                           n_led[sirt_pkg::LED_REST],
                           n_led[sirt_pkg::LED_STUDY],
                           n_color,
                           n_units,
                           n_remaining,
                           n_mode};
        end
    end

endmodule

FILE: rtl/core/sirt_checker.sv
`include "assert_macros.svh"

module sirt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic [2:0] w_mode;
    logic [5:0] w_units;
    logic [2:0] w_color;
    logic       w_study_led;
    logic       w_rest_led;
    logic       w_config_led;
    logic       w_in_config;
    logic       w_in_alert;

    assign w_mode       = m_axis_tdata[2:0];
    assign w_units      = m_axis_tdata[20:15];
    assign w_color      = m_axis_tdata[23:21];
    assign w_study_led  = m_axis_tdata[24];
    assign w_rest_led   = m_axis_tdata[25];
    assign w_config_led = m_axis_tdata[26];
    assign w_in_config  = (w_mode == sirt_pkg::MODE_CONFIG);
    assign w_in_alert   = (w_mode == sirt_pkg::MODE_ALERT);

    // no result right after reset
    `SIRT_ASSERT_ALWAYS(a_rst_no_out, i_clk, $past(!i_rst_n) |-> !m_axis_tvalid, "result after reset")

    // stalled result holds
    `SIRT_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // config LED lit exactly in config mode
    `SIRT_ASSERT(a_cfg_led, i_clk, i_rst_n, m_axis_tvalid |-> (w_config_led == w_in_config), "config LED out of step with mode")

    // phase LEDs dark in config mode
    `SIRT_ASSERT(a_cfg_dark, i_clk, i_rst_n, m_axis_tvalid && w_in_config |-> !w_study_led && !w_rest_led, "phase LED lit in config")

    // alert shows either the full colored matrix or nothing
    `SIRT_ASSERT(a_alert_show, i_clk, i_rst_n, m_axis_tvalid && w_in_alert |-> (w_units == 6'd0 && w_color == sirt_pkg::COLOR_OFF) || (w_units == sirt_pkg::MATRIX_UNITS && (w_color == sirt_pkg::COLOR_YELLOW || w_color == sirt_pkg::COLOR_WHITE)), "bad alert display")

endmodule

bind study_rest_interval_timer sirt_checker u_sirt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: tb/study_rest_interval_timer_tb.sv
module study_rest_interval_timer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // lit units during the on half of the alert flash
    localparam int ALERT_UNITS = (sirt_pkg::MATRIX_CELLS > 63) ? 63 : sirt_pkg::MATRIX_CELLS;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLDOFF_CYCLES = 400;

    // one poll: active-low button levels plus the axis sample
    typedef struct {
        bit          phase_btn;
        bit          pause_btn;
        bit          joy_btn;
        logic [11:0] axis;
    } t_poll;

    // what the block reports after one poll
    typedef struct {
        sirt_pkg::t_mode mode;
        logic [11:0]     secs;
        logic [5:0]      units;
        logic [2:0]      color;
        bit              study_led;
        bit              rest_led;
        bit              config_led;
    } t_timer_status;

    // Timer scoreboard: tracks the timer state poll by poll and keeps the
    // status each accepted poll should produce, oldest first.
    class t_timer_scoreboard;
        // register copies
        logic [7:0]  pps, blink_len, long_len, flash_len;
        logic [11:0] axis_lo, axis_hi;
        logic [5:0]  min_m, max_m;
        // timer state
        sirt_pkg::t_mode mode;
        bit          cur_phase;
        logic [11:0] secs;
        logic [5:0]  study_m, rest_m, shown;
        logic [7:0]  sec_cnt, blink_cnt, press_cnt, flash_cnt;
        bit          blink_lvl, long_done, flash_lvl;
        logic [2:0]  prev_lvls, leds;

        t_timer_status pending[$];
        int errors, checked, alerts, config_entries;

        function new();
            pps = 8'd10; blink_len = 8'd5; long_len = 8'd20; flash_len = 8'd2;
            axis_lo = 12'd150; axis_hi = 12'd4000; min_m = 6'd1; max_m = 6'd50;
            mode = sirt_pkg::MODE_STUDY; cur_phase = 1'b0; secs = 12'd1500;
            study_m = 6'd25; rest_m = 6'd5; shown = '0;
            sec_cnt = '0; blink_cnt = '0; press_cnt = '0; flash_cnt = '0;
            blink_lvl = 1'b0; long_done = 1'b0; flash_lvl = 1'b1;
            prev_lvls = 3'b111; leds = '0;
            errors = 0; checked = 0; alerts = 0; config_entries = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] val);
            case (idx)
                sirt_pkg::REG_POLLS_PER_SEC: pps = val[7:0];
                sirt_pkg::REG_BLINK_POLLS:   blink_len = val[7:0];
                sirt_pkg::REG_LONG_POLLS:    long_len = val[7:0];
                sirt_pkg::REG_FLASH_POLLS:   flash_len = val[7:0];
                sirt_pkg::REG_AXIS_LOW:      axis_lo = val[11:0];
                sirt_pkg::REG_AXIS_HIGH:     axis_hi = val[11:0];
                sirt_pkg::REG_MIN_MINUTES:   min_m = val[5:0];
                sirt_pkg::REG_MAX_MINUTES:   max_m = val[5:0];
                default: ;
            endcase
        endfunction

        function sirt_pkg::t_mode phase_mode(bit ph);
            return ph ? sirt_pkg::MODE_REST : sirt_pkg::MODE_STUDY;
        endfunction

        function logic [11:0] phase_len(bit ph);
            return (ph ? rest_m : study_m) * 12'd60;
        endfunction

        function void start_phase(bit ph);
            cur_phase = ph;
            mode = phase_mode(ph);
            secs = phase_len(ph);
        endfunction

        // one joystick step of a phase length, kept inside min/max
        function logic [5:0] stepped(logic [5:0] mins, logic [11:0] axis);
            if (axis <= axis_lo && mins > min_m) return mins - 6'd1;
            if (axis >= axis_hi && mins < max_m) return mins + 6'd1;
            return mins;
        endfunction

        function void note_poll(t_poll p);
            bit ph_fall, pa_fall, jy_fall;
            int units;
            t_timer_status r;
            ph_fall = prev_lvls[0] && !p.phase_btn;
            pa_fall = prev_lvls[1] && !p.pause_btn;
            jy_fall = prev_lvls[2] && !p.joy_btn;

            // long-press tracking, frozen during the alert
            if (mode != sirt_pkg::MODE_ALERT) begin
                if (jy_fall) begin
                    press_cnt = '0;
                    long_done = 1'b0;
                end
                if (!p.joy_btn && !long_done) begin
                    if (press_cnt != 8'hFF) press_cnt = press_cnt + 8'd1;
                    if (press_cnt > long_len) begin
                        leds[sirt_pkg::LED_CONFIG] = 1'b0;
                        long_done = 1'b1;
                        if (mode == sirt_pkg::MODE_CONFIG) begin
                            mode = phase_mode(cur_phase);
                        end else begin
                            // from pause the saved phase stays as it is
                            if (mode != sirt_pkg::MODE_PAUSED) cur_phase = mode[0];
                            mode = sirt_pkg::MODE_CONFIG;
                            leds = '0;
                            leds[sirt_pkg::LED_CONFIG] = 1'b1;
                            config_entries++;
                        end
                    end
                end
            end

            if (mode == sirt_pkg::MODE_CONFIG) begin
                if (cur_phase) rest_m = stepped(rest_m, p.axis);
                else study_m = stepped(study_m, p.axis);
                secs = phase_len(cur_phase);
            end else if (mode == sirt_pkg::MODE_ALERT) begin
                if (!p.phase_btn) begin
                    start_phase(!cur_phase);
                    sec_cnt = '0;
                end else begin
                    flash_cnt = flash_cnt + 8'd1;
                    if (flash_cnt >= flash_len) begin
                        flash_lvl = !flash_lvl;
                        flash_cnt = '0;
                    end
                end
            end else begin
                if (ph_fall && mode != sirt_pkg::MODE_PAUSED) start_phase(!mode[0]);
                if (pa_fall) begin
                    if (mode != sirt_pkg::MODE_PAUSED) begin
                        cur_phase = mode[0];
                        mode = sirt_pkg::MODE_PAUSED;
                    end else begin
                        mode = phase_mode(cur_phase);
                    end
                end
                if (mode == sirt_pkg::MODE_STUDY || mode == sirt_pkg::MODE_REST) begin
                    sec_cnt = sec_cnt + 8'd1;
                    if (sec_cnt >= pps) begin
                        sec_cnt = '0;
                        if (secs != '0) begin
                            secs = secs - 12'd1;
                        end else if (!p.phase_btn) begin
                            // phase button already held at time-out
                            start_phase(!mode[0]);
                        end else begin
                            cur_phase = mode[0];
                            mode = sirt_pkg::MODE_ALERT;
                            flash_lvl = 1'b1;
                            flash_cnt = '0;
                            alerts++;
                        end
                    end
                end else if (mode == sirt_pkg::MODE_PAUSED) begin
                    blink_cnt = blink_cnt + 8'd1;
                    if (blink_cnt >= blink_len) begin
                        blink_lvl = !blink_lvl;
                        leds[cur_phase ? sirt_pkg::LED_REST : sirt_pkg::LED_STUDY] = blink_lvl;
                        blink_cnt = '0;
                    end
                end
            end

            prev_lvls = {p.joy_btn, p.pause_btn, p.phase_btn};

            r.mode = mode;
            r.secs = secs;
            if (mode == sirt_pkg::MODE_ALERT) begin
                r.units = flash_lvl ? 6'(ALERT_UNITS) : 6'd0;
                r.color = !flash_lvl ? sirt_pkg::COLOR_OFF :
                          (cur_phase ? sirt_pkg::COLOR_WHITE : sirt_pkg::COLOR_YELLOW);
            end else if (mode == sirt_pkg::MODE_PAUSED) begin
                r.units = shown;
                r.color = cur_phase ? sirt_pkg::COLOR_RED : sirt_pkg::COLOR_GREEN;
            end else begin
                units = (int'(secs) + 59) / 60;
                if (units > 63) units = 63;
                shown = 6'(units);
                r.units = shown;
                r.color = cur_phase ? sirt_pkg::COLOR_RED : sirt_pkg::COLOR_GREEN;
            end
            r.study_led = leds[sirt_pkg::LED_STUDY];
            r.rest_led = leds[sirt_pkg::LED_REST];
            r.config_led = leds[sirt_pkg::LED_CONFIG];
            pending.push_back(r);
        endfunction

        function void match(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] d);
            t_timer_status r;
            if (pending.size() == 0) begin
                $error("result transfer with no poll waiting: tdata %h", d);
                errors++;
                return;
            end
            r = pending.pop_front();
            checked++;
            match("mode", int'(r.mode), int'(d[2:0]));
            match("seconds_left", int'(r.secs), int'(d[14:3]));
            match("display_units", int'(r.units), int'(d[20:15]));
            match("display_color", int'(r.color), int'(d[23:21]));
            match("study_led", int'(r.study_led), int'(d[24]));
            match("rest_led", int'(r.rest_led), int'(d[25]));
            match("config_led", int'(r.config_led), int'(d[26]));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;  // [0] phase, [1] pause, [2] joy, [14:3] axis, [15] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;       // [2:0] mode, [14:3] secs, [20:15] units,
                                     // [23:21] color, [24] study, [25] rest, [26] config led
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    study_rest_interval_timer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_timer_scoreboard sb;
    t_poll           poll_q[$];     // polls waiting to be offered
    t_poll           held_poll;     // poll currently on s_axis_tdata
    int              queued = 0;
    int              send_idle_pct = 32;
    int              recv_idle_pct = 45;
    int              holdoff_asked = 0;
    int              holdoff_seen = 0;
    int              holdoff_left = 0;

    // Sender: note the poll at its transfer, then offer the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) sb.note_poll(held_poll);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (poll_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_poll = poll_q.pop_front();
                    s_axis_tdata <= {1'b0, held_poll.axis, held_poll.joy_btn,
                                     held_poll.pause_btn, held_poll.phase_btn};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result transfer; random stalls plus an occasional
    // long hold-off counted here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (holdoff_seen != holdoff_asked) begin
                holdoff_seen = holdoff_asked;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_register(idx, val);
    endtask

    task automatic set_timer(int pps, int blink, int longp, int flash,
                             int lo, int hi, int mn, int mx);
        apb_write(sirt_pkg::REG_POLLS_PER_SEC, pps);
        apb_write(sirt_pkg::REG_BLINK_POLLS, blink);
        apb_write(sirt_pkg::REG_LONG_POLLS, longp);
        apb_write(sirt_pkg::REG_FLASH_POLLS, flash);
        apb_write(sirt_pkg::REG_AXIS_LOW, lo);
        apb_write(sirt_pkg::REG_AXIS_HIGH, hi);
        apb_write(sirt_pkg::REG_MIN_MINUTES, mn);
        apb_write(sirt_pkg::REG_MAX_MINUTES, mx);
    endtask

    // Block is idle once every queued poll has its result checked; a few
    // quiet cycles follow before any register write.
    task automatic drain();
        while (sb.checked != queued)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // axis samples biased toward the step thresholds and the rails
    function automatic logic [11:0] pick_axis();
        int r;
        r = $urandom_range(9);
        if (r < 3) return 12'($urandom_range(int'(sb.axis_lo), 0));
        if (r < 6) return 12'($urandom_range(4095, int'(sb.axis_hi)));
        if (r == 6) return $urandom_range(1) ? 12'hFFF : 12'h000;
        return 12'($urandom_range(4095));
    endfunction

    function automatic void push_poll(bit ph, bit pa, bit jy, logic [11:0] axis);
        t_poll p;
        p.phase_btn = ph;
        p.pause_btn = pa;
        p.joy_btn = jy;
        p.axis = axis;
        poll_q.push_back(p);
        queued++;
    endfunction

    function automatic void add_polls(int n, bit ph, bit pa, bit jy);
        repeat (n) push_poll(ph, pa, jy, pick_axis());
    endfunction

    // Random polls as button gestures: taps, holds, long presses, run-downs
    // to zero, and some raw noise.
    task automatic queue_polls(int target);
        int start_count, r, hold;
        start_count = queued;
        while (queued - start_count < target) begin
            r = $urandom_range(99);
            if (r < 18) begin
                add_polls($urandom_range(1, 12), 1'b1, 1'b1, 1'b1);
            end else if (r < 28) begin
                // long quiet stretch so the countdown can reach zero
                add_polls($urandom_range(40, 200), 1'b1, 1'b1, 1'b1);
            end else if (r < 42) begin
                add_polls($urandom_range(1, 3), 1'b0, 1'b1, 1'b1);
                add_polls($urandom_range(1, 2), 1'b1, 1'b1, 1'b1);
            end else if (r < 48) begin
                add_polls($urandom_range(4, 20), 1'b0, 1'b1, 1'b1);
            end else if (r < 62) begin
                add_polls($urandom_range(1, 3), 1'b1, 1'b0, 1'b1);
                add_polls($urandom_range(1, 8), 1'b1, 1'b1, 1'b1);
            end else if (r < 78) begin
                hold = int'(sb.long_len) + 1 + $urandom_range(0, 4);
                add_polls(hold, 1'b1, 1'b1, 1'b0);
                add_polls($urandom_range(1, 2), 1'b1, 1'b1, 1'b1);
            end else if (r < 86) begin
                hold = (sb.long_len > 8) ? 8 : int'(sb.long_len);
                add_polls($urandom_range(1, hold), 1'b1, 1'b1, 1'b0);
                add_polls(1, 1'b1, 1'b1, 1'b1);
            end else if (r < 95) begin
                repeat ($urandom_range(1, 4))
                    push_poll(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 12'($urandom_range(4095)));
            end else begin
                add_polls($urandom_range(1, 3), 1'b0, 1'b0, 1'b0);
                add_polls(1, 1'b1, 1'b1, 1'b1);
            end
        end
    endtask

    initial begin
        int lo, hi, mn, target;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed polls at reset settings.
        push_poll(1'b1, 1'b1, 1'b1, 12'd2048);
        push_poll(1'b1, 1'b1, 1'b1, 12'h000);
        push_poll(1'b1, 1'b1, 1'b1, 12'hFFF);
        push_poll(1'b0, 1'b0, 1'b0, 12'h000);  // all pressed: swap then pause in one poll
        push_poll(1'b1, 1'b1, 1'b1, 12'hFFF);
        push_poll(1'b0, 1'b1, 1'b1, 12'd2048); // phase edge while paused is ignored
        push_poll(1'b1, 1'b0, 1'b1, 12'd2048); // resume
        push_poll(1'b1, 1'b1, 1'b1, 12'd2048);
        push_poll(1'b0, 1'b1, 1'b1, 12'd2048); // swap back to study
        push_poll(1'b1, 1'b1, 1'b1, 12'd2048);
        push_poll(1'b1, 1'b0, 1'b1, 12'd2048); // pause, then blink the saved LED
        add_polls(6, 1'b1, 1'b1, 1'b1);
        push_poll(1'b1, 1'b0, 1'b1, 12'd2048);
        push_poll(1'b1, 1'b1, 1'b1, 12'd2048);
        add_polls(3, 1'b1, 1'b1, 1'b0);        // short joystick press
        push_poll(1'b1, 1'b1, 1'b1, 12'hFFF);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            // idle pattern: receiver heavy, then sender heavy, then none
            send_idle_pct = (ph < 3) ? 32 : (ph < 6) ? 45 : 0;
            recv_idle_pct = (ph < 3) ? 45 : (ph < 6) ? 32 : 0;
            target = 230;
            case (ph)
                0: set_timer(1, 1, 1, 1, 150, 4000, 1, 2);
                1: begin
                    set_timer(255, 255, 255, 255, 4095, 4095, 63, 63);
                    target = 150;
                end
                default: begin
                    lo = $urandom_range(2047);
                    hi = $urandom_range(4095, 2048);
                    if (ph == 4) begin
                        lo = 0;
                        hi = 0;
                    end else if (ph == 6) begin
                        lo = 4095;
                        hi = 0;
                    end
                    mn = $urandom_range(1, 4);
                    set_timer($urandom_range(1, 3), $urandom_range(1, 6),
                              $urandom_range(1, 8), $urandom_range(1, 4),
                              lo, hi, mn, $urandom_range(63, mn));
                end
            endcase
            queue_polls(target / 2);
            if (ph == 1 || ph == 7) holdoff_asked++;
            // sender stops here until every result is back
            drain();
            queue_polls(target / 2);
            drain();
        end

        repeat (4) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Checked %0d polls over 10 register settings (defaults and extremes included).",
                 sb.checked);
        $display("Countdown ran out %0d times; config mode was entered %0d times.",
                 sb.alerts, sb.config_entries);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
